>>> hw/rtl/spimbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spimbs_pkg
// Shared types and constants of the SPI master bit shifter.
// ----------------------------------------------------------------------------
package spimbs_pkg;

   localparam int WORD_BITS        = 16;
   localparam int MAX_BITS_DEFAULT = 16;
   localparam int CMD_QUEUE_DEPTH  = 2;

   localparam logic [7:0] HALF_PERIOD_RESET = 8'd12;

   // operation codes
   localparam logic [1:0] OP_SELECT   = 2'd0;
   localparam logic [1:0] OP_TRANSMIT = 2'd1;
   localparam logic [1:0] OP_RECEIVE  = 2'd2;

   // device codes for select
   localparam logic [1:0] DEV_FIRST  = 2'd1;
   localparam logic [1:0] DEV_SECOND = 2'd2;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_SELECT  = 2'd1,
      KIND_TX      = 2'd2,
      KIND_RX      = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [1:0]  device;
      logic [15:0] tx_data;
      logic [4:0]  bit_count;
      logic [15:0] miso_levels;
   } req_type;

   typedef struct packed {
      logic        clock_pulsed;
      logic        mosi_level;
      logic        select_first_n;
      logic        select_second_n;
      logic [3:0]  bit_position;
      logic [15:0] rx_word;
      logic        last;
   } rsp_type;

   // classified command as held in the queue
   typedef struct packed {
      kind_type    kind;
      logic [1:0]  device;
      logic [15:0] tx_data;
      logic [4:0]  bit_count;
      logic [15:0] miso_levels;
   } cmd_type;

endpackage
`default_nettype wire

>>> hw/rtl/spimbs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spimbs_front
// Accepts request items, clamps the bit count, classifies each command and
// holds it in a short queue for the shifter.
// ----------------------------------------------------------------------------
module spimbs_front #(
   parameter int MAX_BITS = spimbs_pkg::MAX_BITS_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  spimbs_pkg::req_type  req_data,
   output logic                 cmd_valid,
   input  wire                  cmd_pop,
   output spimbs_pkg::cmd_type  cmd_data
);

   localparam int LIMIT = (MAX_BITS < spimbs_pkg::WORD_BITS) ? MAX_BITS
                                                            : spimbs_pkg::WORD_BITS;
   localparam int DEPTH = spimbs_pkg::CMD_QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);

   spimbs_pkg::cmd_type   queue_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]        fill_ff, fill_in;
   logic                  push;
   logic                  pop;
   logic [4:0]            count_clamped;
   spimbs_pkg::cmd_type   cmd_new;

   always_comb begin
      count_clamped = (req_data.bit_count > 5'(LIMIT)) ? 5'(LIMIT) : req_data.bit_count;
      cmd_new.device      = req_data.device;
      cmd_new.tx_data     = req_data.tx_data;
      cmd_new.bit_count   = count_clamped;
      cmd_new.miso_levels = req_data.miso_levels;
      case (req_data.operation)
         spimbs_pkg::OP_SELECT:   cmd_new.kind = spimbs_pkg::KIND_SELECT;
         spimbs_pkg::OP_TRANSMIT: cmd_new.kind = (count_clamped == 5'd0) ?
                                                 spimbs_pkg::KIND_NONE : spimbs_pkg::KIND_TX;
         spimbs_pkg::OP_RECEIVE:  cmd_new.kind = (count_clamped == 5'd0) ?
                                                 spimbs_pkg::KIND_NONE : spimbs_pkg::KIND_RX;
         default:                 cmd_new.kind = spimbs_pkg::KIND_NONE;
      endcase
   end

   assign req_stall = (fill_ff == (PTR_W+1)'(DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd_data  = queue_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/spimbs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spimbs_back
// Bit shifter: runs one command at a time, times the serial clock half
// periods, tracks the select and data-out levels and registers each result.
// ----------------------------------------------------------------------------
module spimbs_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire  [7:0]           half_period,
   input  wire                  cmd_valid,
   output logic                 cmd_pop,
   input  spimbs_pkg::cmd_type  cmd_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output spimbs_pkg::rsp_type  rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SINGLE = 5'b00010,
      ST_LOW    = 5'b00100,
      ST_HIGH   = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   spimbs_pkg::cmd_type  cmd_ff, cmd_in;
   logic [3:0]           pos_ff, pos_in;
   logic [15:0]          rx_ff, rx_in;
   logic [7:0]           cnt_ff, cnt_in;
   logic                 mosi_ff, mosi_in;
   logic                 sel_first_ff, sel_first_in;
   logic                 sel_second_ff, sel_second_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   spimbs_pkg::rsp_type  rsp_ff, rsp_in;
   logic                 slot_free;
   logic                 tick_done;
   logic [15:0]          rx_next;
   logic [3:0]           pos_start;
   logic [3:0]           pos_down;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign tick_done = ({1'b0, cnt_ff} + 9'd1) >= {1'b0, half_period};
   assign rx_next   = rx_ff | (16'(cmd_ff.miso_levels[pos_ff]) << pos_ff);
   assign pos_start = 4'(cmd_data.bit_count - 5'd1);
   assign pos_down  = 4'(pos_ff - 4'd1);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      rx_in         = rx_ff;
      cnt_in        = cnt_ff;
      mosi_in       = mosi_ff;
      sel_first_in  = sel_first_ff;
      sel_second_in = sel_second_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      cmd_pop       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_data;
               pos_in  = pos_start;
               rx_in   = '0;
               cnt_in  = '0;
               if (cmd_data.kind == spimbs_pkg::KIND_TX ||
                   cmd_data.kind == spimbs_pkg::KIND_RX) begin
                  state_in = ST_LOW;
                  if (cmd_data.kind == spimbs_pkg::KIND_TX) begin
                     mosi_in = cmd_data.tx_data[pos_start];
                  end
               end else begin
                  state_in = ST_SINGLE;
               end
            end
         end
         ST_SINGLE: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.clock_pulsed    = 1'b0;
               rsp_in.mosi_level      = mosi_ff;
               rsp_in.select_first_n  = sel_first_ff;
               rsp_in.select_second_n = sel_second_ff;
               rsp_in.bit_position    = '0;
               rsp_in.rx_word         = '0;
               rsp_in.last            = 1'b1;
               if (cmd_ff.kind == spimbs_pkg::KIND_SELECT) begin
                  if (cmd_ff.device == spimbs_pkg::DEV_FIRST) begin
                     sel_first_in          = 1'b0;
                     rsp_in.select_first_n = 1'b0;
                  end else if (cmd_ff.device == spimbs_pkg::DEV_SECOND) begin
                     sel_second_in          = 1'b0;
                     rsp_in.select_second_n = 1'b0;
                  end else begin
                     sel_first_in           = 1'b1;
                     sel_second_in          = 1'b1;
                     rsp_in.select_first_n  = 1'b1;
                     rsp_in.select_second_n = 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         // serial clock low half: data-out already set up
         ST_LOW: begin
            cnt_in = 8'(cnt_ff + 8'd1);
            if (tick_done) begin
               cnt_in   = '0;
               state_in = ST_HIGH;
            end
         end
         ST_HIGH: begin
            cnt_in = 8'(cnt_ff + 8'd1);
            if (tick_done) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         // falling edge seen: sample data-in and hand over the item
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.clock_pulsed    = 1'b1;
               rsp_in.mosi_level      = mosi_ff;
               rsp_in.select_first_n  = sel_first_ff;
               rsp_in.select_second_n = sel_second_ff;
               rsp_in.bit_position    = pos_ff;
               rsp_in.last            = (pos_ff == 4'd0);
               if (cmd_ff.kind == spimbs_pkg::KIND_RX) begin
                  rsp_in.rx_word = rx_next;
                  rx_in          = rx_next;
               end else begin
                  rsp_in.rx_word = '0;
               end
               if (pos_ff == 4'd0) begin
                  state_in = ST_IDLE;
                  if (cmd_ff.kind == spimbs_pkg::KIND_TX) begin
                     mosi_in = 1'b0;
                  end
               end else begin
                  pos_in   = pos_down;
                  state_in = ST_LOW;
                  if (cmd_ff.kind == spimbs_pkg::KIND_TX) begin
                     mosi_in = cmd_ff.tx_data[pos_down];
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mosi_ff       <= 1'b0;
         sel_first_ff  <= 1'b1;
         sel_second_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         mosi_ff       <= mosi_in;
         sel_first_ff  <= sel_first_in;
         sel_second_ff <= sel_second_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      pos_ff <= pos_in;
      rx_ff  <= rx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> hw/rtl/spi_master_bit_shifter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spi_master_bit_shifter
// SPI master, mode 0, MSB first, with two active-low device selects.
//
//   channel | ports              | direction | moves
//   --------+--------------------+-----------+------------------------------
//   req     | valid/stall/data   | in        | one command item
//   rsp     | valid/stall/data   | out       | one item per clock pulse, or one per command without pulses
//   csr     | write_enable/data  | in        | half period in cycles
//
// A transmit or receive command leaves the queue and then runs each bit through
// a low half, a high half and a hand-over state, the halves timed by the half
// period timer in the shifter; a command without clock pulses yields a single
// result item. A two-entry command queue sits between the front and the
// shifter, so req is taken while the shifter runs. Reset (synchronous)
// deselects both devices and drives data-out low.
// A stalled rsp holds the shifter at the end of the current pulse.
// ----------------------------------------------------------------------------
module spi_master_bit_shifter #(
   parameter int MAX_BITS = spimbs_pkg::MAX_BITS_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  spimbs_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output spimbs_pkg::rsp_type  rsp_data,
   input  wire                  csr_write_enable,
   input  wire  [7:0]           csr_write_data
);

   logic [7:0]           half_period_ff;
   logic [7:0]           half_period_in;
   logic                 cmd_valid;
   logic                 cmd_pop;
   spimbs_pkg::cmd_type  cmd_data;

   assign half_period_in = csr_write_enable ? csr_write_data : half_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= spimbs_pkg::HALF_PERIOD_RESET;
      end else begin
         half_period_ff <= half_period_in;
      end
   end

   spimbs_front #(
      .MAX_BITS (MAX_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   spimbs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .half_period (half_period_ff),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd_data    (cmd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

>>> sim/spi_master_bit_shifter_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spi_master_bit_shifter_tb
// Self-checking bench for the SPI master bit shifter. A queue-fed driver
// offers command items and predicts the pin activity of each accepted one.
// A monitor compares every result item with the oldest prediction. The half
// period is changed between phases, including zero, one and 255. Phases
// run with random idling on both sides; one phase has an idle-free stretch,
// and another a long receiver hold-off.
// ----------------------------------------------------------------------------
module spi_master_bit_shifter_tb;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [1:0] DEV_NONE    = 2'd0;
   localparam logic [1:0] DEV_SPARE   = 2'd3;
   localparam int         BIT_LIMIT   =
      (spimbs_pkg::MAX_BITS_DEFAULT < spimbs_pkg::WORD_BITS) ?
      spimbs_pkg::MAX_BITS_DEFAULT : spimbs_pkg::WORD_BITS;
   localparam int         IDLE_PCT    = 31;
   localparam int         HOLD_CYCLES = 400;
   localparam int         CYCLE_LIMIT = 2_000_000;
   localparam int         REPORT_MAX  = 10;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   spimbs_pkg::req_type  req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   spimbs_pkg::rsp_type  rsp_data;
   logic                 csr_write_enable = 1'b0;
   logic [7:0]           csr_write_data = 8'd0;

   spi_master_bit_shifter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted pin state
   logic sel_first_n  = 1'b1;
   logic sel_second_n = 1'b1;
   logic mosi_now     = 1'b0;
   int   period_now   = int'(spimbs_pkg::HALF_PERIOD_RESET);

   spimbs_pkg::req_type pending_cmds[$];
   spimbs_pkg::rsp_type expected_pins[$];
   int      error_count = 0;
   int      cycle_count = 0;
   logic    calm = 1'b0;
   logic    burst = 1'b0;
   logic    hold_done = 1'b0;
   int      hold_left = 0;

   function automatic spimbs_pkg::req_type make_cmd(input logic [1:0] op,
                                                    input logic [1:0] dev,
                                                    input logic [15:0] tx,
                                                    input logic [4:0] count,
                                                    input logic [15:0] miso);
      spimbs_pkg::req_type c;
      c.operation   = op;
      c.device      = dev;
      c.tx_data     = tx;
      c.bit_count   = count;
      c.miso_levels = miso;
      return c;
   endfunction

   function automatic string pins_text(input spimbs_pkg::rsp_type r);
      return $sformatf("pulse=%0d mosi=%0d sel1_n=%0d sel2_n=%0d pos=%0d rx=%h last=%0d",
                       r.clock_pulsed, r.mosi_level, r.select_first_n,
                       r.select_second_n, r.bit_position, r.rx_word, r.last);
   endfunction

   task automatic predict_pins(input spimbs_pkg::req_type cmd);
      spimbs_pkg::rsp_type r;
      int          count;
      int          pulses;
      logic [15:0] rx_acc;
      count  = cmd.bit_count;
      if (count > BIT_LIMIT) count = BIT_LIMIT;
      pulses = 0;
      rx_acc = '0;
      if (cmd.operation == spimbs_pkg::OP_SELECT) begin
         if (cmd.device == spimbs_pkg::DEV_FIRST) begin
            sel_first_n = 1'b0;
         end else if (cmd.device == spimbs_pkg::DEV_SECOND) begin
            sel_second_n = 1'b0;
         end else begin
            sel_first_n  = 1'b1;
            sel_second_n = 1'b1;
         end
      end else if (cmd.operation == spimbs_pkg::OP_TRANSMIT ||
                   cmd.operation == spimbs_pkg::OP_RECEIVE) begin
         for (int pos = count - 1; pos >= 0; pos--) begin
            if (cmd.operation == spimbs_pkg::OP_TRANSMIT) begin
               mosi_now = cmd.tx_data[pos];
            end else begin
               rx_acc[pos] = cmd.miso_levels[pos];
            end
            r.clock_pulsed    = 1'b1;
            r.mosi_level      = mosi_now;
            r.select_first_n  = sel_first_n;
            r.select_second_n = sel_second_n;
            r.bit_position    = 4'(pos);
            r.rx_word         = rx_acc;
            r.last            = (pos == 0);
            expected_pins.push_back(r);
            pulses++;
         end
         // data-out returns low once a transmit is done
         if (cmd.operation == spimbs_pkg::OP_TRANSMIT) mosi_now = 1'b0;
      end
      if (pulses == 0) begin
         r                 = '0;
         r.mosi_level      = mosi_now;
         r.select_first_n  = sel_first_n;
         r.select_second_n = sel_second_n;
         r.last            = 1'b1;
         expected_pins.push_back(r);
      end
   endtask

   function automatic spimbs_pkg::req_type random_cmd(input int max_count,
                                                      input bit allow_long);
      spimbs_pkg::req_type c;
      int      pick;
      c.device      = 2'($urandom_range(0, 3));
      c.tx_data     = 16'($urandom);
      c.miso_levels = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 20) c.operation = spimbs_pkg::OP_SELECT;
      else if (pick < 58) c.operation = spimbs_pkg::OP_TRANSMIT;
      else if (pick < 96) c.operation = spimbs_pkg::OP_RECEIVE;
      else c.operation = OP_UNUSED;
      pick = $urandom_range(0, 99);
      if (allow_long && pick < 6) c.bit_count = 5'($urandom_range(17, 31));
      else if (allow_long && pick < 12) c.bit_count = 5'(spimbs_pkg::WORD_BITS);
      else c.bit_count = 5'($urandom_range(0, max_count));
      return c;
   endfunction

   // mostly select / shift / deselect sequences, some stray items between them
   task automatic queue_traffic(input int n_items, input int max_count);
      int added;
      int shifts;
      added = 0;
      while (added < n_items) begin
         if ($urandom_range(0, 99) < 25) begin
            pending_cmds.push_back(random_cmd(max_count, 1'b1));
            added++;
         end else begin
            pending_cmds.push_back(make_cmd(spimbs_pkg::OP_SELECT,
                                   ($urandom_range(0, 1) != 0) ?
                                   spimbs_pkg::DEV_FIRST : spimbs_pkg::DEV_SECOND,
                                   16'($urandom), 5'($urandom), 16'($urandom)));
            shifts = $urandom_range(1, 4);
            repeat (shifts) begin
               pending_cmds.push_back(make_cmd(($urandom_range(0, 1) != 0) ?
                                      spimbs_pkg::OP_TRANSMIT : spimbs_pkg::OP_RECEIVE,
                                      2'($urandom), 16'($urandom),
                                      5'($urandom_range(1, max_count)),
                                      16'($urandom)));
            end
            if ($urandom_range(0, 99) < 80) begin
               pending_cmds.push_back(make_cmd(spimbs_pkg::OP_SELECT,
                                      ($urandom_range(0, 1) != 0) ?
                                      DEV_NONE : DEV_SPARE, 16'($urandom), 5'($urandom),
                                      16'($urandom)));
               added++;
            end
            added += shifts + 1;
         end
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_pins.size() != 0);
      // a quiet gap, scaled with the half period, before the next phase
      repeat (2 * period_now + 8) @(posedge clock);
   endtask

   task automatic set_half_period(input logic [7:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      period_now = (value == 0) ? 1 : value;
   endtask

   // driver: predicts on acceptance, then offers the next item or idles
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) predict_pins(req_data);
         if (pending_cmds.size() != 0 &&
             (calm || burst || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_data  <= pending_cmds.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver hold-off, counted on its own
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (burst && !hold_done && rsp_valid) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // monitor: checks each accepted result, then decides on stalling
   always @(posedge clock) begin
      spimbs_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pins.size() == 0) begin
               if (error_count < REPORT_MAX)
                  $display("unexpected result item: %s", pins_text(rsp_data));
               error_count++;
            end else begin
               want = expected_pins.pop_front();
               if (rsp_data !== want) begin
                  if (error_count < REPORT_MAX)
                     $display("mismatch: expected %s, got %s", pins_text(want),
                              pins_text(rsp_data));
                  error_count++;
               end
            end
         end
         if (hold_left > 0 || (burst && !hold_done && rsp_valid)) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !(calm || burst) && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed commands at the reset half period
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_RECEIVE, DEV_NONE, 16'h0000, 5'd3,
                                      16'hFFFF));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_SELECT, spimbs_pkg::DEV_FIRST,
                                      16'hFFFF, 5'd31, 16'hFFFF));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_TRANSMIT, DEV_SPARE, 16'hFFFF, 5'd16,
                                      16'h0000));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_TRANSMIT, DEV_NONE, 16'hA5A5, 5'd16,
                                      16'hFFFF));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_TRANSMIT, DEV_NONE, 16'hFFFF, 5'd0,
                                      16'h0000));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_TRANSMIT, DEV_NONE, 16'h0001, 5'd1,
                                      16'h0000));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_TRANSMIT, DEV_NONE, 16'h5A5A, 5'd31,
                                      16'h0000));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_TRANSMIT, DEV_NONE, 16'h8001, 5'd17,
                                      16'h0000));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_SELECT, spimbs_pkg::DEV_SECOND,
                                      16'h0000, 5'd0, 16'h0000));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_RECEIVE, DEV_SPARE, 16'hFFFF, 5'd16,
                                      16'hFFFF));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_RECEIVE, DEV_NONE, 16'h0000, 5'd16,
                                      16'h0000));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_RECEIVE, DEV_NONE, 16'h0000, 5'd16,
                                      16'h8421));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_RECEIVE, DEV_NONE, 16'hFFFF, 5'd0,
                                      16'hFFFF));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_RECEIVE, DEV_NONE, 16'h0000, 5'd31,
                                      16'h3C3C));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_RECEIVE, DEV_NONE, 16'h0000, 5'd1,
                                      16'h0001));
      pending_cmds.push_back(make_cmd(OP_UNUSED, spimbs_pkg::DEV_FIRST, 16'hFFFF, 5'd16,
                                      16'hFFFF));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_SELECT, DEV_NONE, 16'h0000, 5'd0,
                                      16'h0000));
      pending_cmds.push_back(make_cmd(OP_UNUSED, DEV_SPARE, 16'h0000, 5'd0, 16'h0000));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_SELECT, spimbs_pkg::DEV_SECOND,
                                      16'h0000, 5'd0, 16'h0000));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_TRANSMIT, DEV_NONE, 16'hC003, 5'd16,
                                      16'h0000));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_SELECT, DEV_SPARE, 16'hFFFF, 5'd31,
                                      16'hFFFF));
      wait_drained();

      // idle-free stretch at the fastest clock
      set_half_period(8'd1);
      calm <= 1'b1;
      queue_traffic(60, 16);
      wait_drained();
      calm <= 1'b0;
      queue_traffic(120, 16);
      wait_drained();

      set_half_period(8'd0);
      queue_traffic(60, 16);
      wait_drained();

      // slowest clock, short commands and one full word
      set_half_period(8'd255);
      repeat (6) pending_cmds.push_back(random_cmd(3, 1'b0));
      pending_cmds.push_back(make_cmd(spimbs_pkg::OP_TRANSMIT, DEV_NONE, 16'($urandom),
                                      5'd16, 16'($urandom)));
      wait_drained();

      // receiver hold-off while the sender keeps offering
      set_half_period(8'd3);
      burst <= 1'b1;
      queue_traffic(80, 16);
      wait_drained();
      burst <= 1'b0;

      set_half_period(8'd2);
      queue_traffic(100, 16);
      wait_drained();

      repeat (600) @(posedge clock);
      if (error_count == 0 && expected_pins.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/spimbs_pkg.sv
hw/rtl/spimbs_front.sv
hw/rtl/spimbs_back.sv
hw/rtl/spi_master_bit_shifter.sv
sim/spi_master_bit_shifter_tb.sv
